// ----- hw/rtl/epp_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the Euler pose point transform.
// No dependencies.
package epp_pkg;

   localparam int COORD_WIDTH        = 32;
   localparam int TRIG_FRACTION_BITS = 16;
   localparam int CSR_WIDTH          = 32;
   localparam int CSR_INDEX_WIDTH    = 3;
   localparam int CORDIC_STEPS       = 31;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ROLL     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PITCH    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_YAW      = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_X = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_Y = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OFFSET_Z = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WIDTH    = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LENGTH   = 3'd7;

   // control bits that travel with each word through the pipe
   typedef struct packed {
      logic valid;
      logic last;
      logic extra;
   } ctl_type;

   // arctan(2^-i) scaled to 2^32 per turn
   function automatic logic [31:0] cordic_atan(input logic [4:0] i);
      case (i)
         5'd0:    return 32'd536870912;
         5'd1:    return 32'd316933406;
         5'd2:    return 32'd167458907;
         5'd3:    return 32'd85004756;
         5'd4:    return 32'd42667331;
         5'd5:    return 32'd21354465;
         5'd6:    return 32'd10679838;
         5'd7:    return 32'd5340245;
         5'd8:    return 32'd2670163;
         5'd9:    return 32'd1335087;
         5'd10:   return 32'd667544;
         5'd11:   return 32'd333772;
         5'd12:   return 32'd166886;
         5'd13:   return 32'd83443;
         5'd14:   return 32'd41722;
         5'd15:   return 32'd20861;
         5'd16:   return 32'd10430;
         5'd17:   return 32'd5215;
         5'd18:   return 32'd2608;
         5'd19:   return 32'd1304;
         5'd20:   return 32'd652;
         5'd21:   return 32'd326;
         5'd22:   return 32'd163;
         5'd23:   return 32'd81;
         5'd24:   return 32'd41;
         5'd25:   return 32'd20;
         5'd26:   return 32'd10;
         5'd27:   return 32'd5;
         5'd28:   return 32'd3;
         5'd29:   return 32'd1;
         5'd30:   return 32'd1;
         default: return 32'd0;
      endcase
   endfunction

endpackage

// ----- hw/rtl/epp_rot.sv -----
`timescale 1ns / 1ps
// Rotation matrix builder: three CORDIC lanes, one step a cycle, then two
// multiply stages forming Rz*Ry*Rx. Depends on epp_pkg.
module epp_rot #(
   parameter int TFB = epp_pkg::TRIG_FRACTION_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [15:0]          roll,
   input  logic [15:0]          pitch,
   input  logic [15:0]          yaw,
   output logic                 busy,
   output logic [8:0][TFB+1:0]  mat
);
   import epp_pkg::*;

   localparam int MW = TFB + 2;
   localparam int SH = 30 - TFB;
   localparam logic signed [MW:0] ONE = (MW + 1)'(1) <<< TFB;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_ROTATE = 3'd2;
   localparam logic [2:0] ST_SCALE  = 3'd3;
   localparam logic [2:0] ST_MUL1   = 3'd4;
   localparam logic [2:0] ST_MUL2   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [4:0]              step_ff, step_in;
   logic signed [33:0]      x_ff [3], x_in [3], y_ff [3], y_in [3];
   logic signed [32:0]      z_ff [3], z_in [3];
   logic [1:0]              q_ff [3], q_in [3];
   logic signed [MW-1:0]    c_ff [3], c_in [3], s_ff [3], s_in [3];
   logic signed [MW-1:0]    pr_ff [10], pr_in [10];
   logic signed [MW-1:0]    mat_ff [9], mat_in [9];

   logic [15:0]             ang [3];
   logic [31:0]             turn_u [3], turn_r [3];
   logic signed [33:0]      cc [3], ss [3], nx [3], ny [3];
   logic signed [32:0]      nz [3];
   logic signed [32:0]      atan_s;

   function automatic logic signed [MW-1:0] to_trig(input logic signed [33:0] v);
      logic signed [33:0] r;
      r = (v + (34'sd1 <<< (SH - 1))) >>> SH;
      if (r > (34'sd1 <<< TFB))
         r = 34'sd1 <<< TFB;
      else if (r < -(34'sd1 <<< TFB))
         r = -(34'sd1 <<< TFB);
      return MW'(r);
   endfunction

   function automatic logic signed [MW-1:0] mr(input logic signed [MW-1:0] a,
                                               input logic signed [MW-1:0] b);
      logic signed [2*MW-1:0] p;
      p = a * b;
      p = (p + ((2 * MW)'(1) <<< (TFB - 1))) >>> TFB;
      return MW'(p);
   endfunction

   function automatic logic signed [MW-1:0] sat1(input logic signed [MW:0] v);
      if (v > ONE)
         return MW'(ONE);
      else if (v < -ONE)
         return MW'(-ONE);
      return MW'(v);
   endfunction

   assign ang[0] = roll;
   assign ang[1] = pitch;
   assign ang[2] = yaw;
   assign atan_s = $signed({1'b0, cordic_atan(step_ff)});

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         turn_u[l] = {ang[l], 16'h0000} + 32'h2000_0000;
         turn_r[l] = {ang[l], 16'h0000} - {turn_u[l][31:30], 30'h0};
         if (z_ff[l] >= 0) begin
            nx[l] = x_ff[l] - (y_ff[l] >>> step_ff);
            ny[l] = y_ff[l] + (x_ff[l] >>> step_ff);
            nz[l] = z_ff[l] - atan_s;
         end else begin
            nx[l] = x_ff[l] + (y_ff[l] >>> step_ff);
            ny[l] = y_ff[l] - (x_ff[l] >>> step_ff);
            nz[l] = z_ff[l] + atan_s;
         end
         case (q_ff[l])
            2'd0:    begin cc[l] = x_ff[l];  ss[l] = y_ff[l];  end
            2'd1:    begin cc[l] = -y_ff[l]; ss[l] = x_ff[l];  end
            2'd2:    begin cc[l] = -x_ff[l]; ss[l] = -y_ff[l]; end
            default: begin cc[l] = y_ff[l];  ss[l] = -x_ff[l]; end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in  = x_ff;
      y_in  = y_ff;
      z_in  = z_ff;
      q_in  = q_ff;
      c_in  = c_ff;
      s_in  = s_ff;
      pr_in = pr_ff;
      mat_in = mat_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start)
               state_in = ST_INIT;
         end
         ST_INIT: begin
            for (int l = 0; l < 3; l++) begin
               q_in[l] = turn_u[l][31:30];
               z_in[l] = 33'($signed(turn_r[l]));
               x_in[l] = CORDIC_GAIN;
               y_in[l] = '0;
            end
            step_in  = '0;
            state_in = ST_ROTATE;
         end
         ST_ROTATE: begin
            x_in = nx;
            y_in = ny;
            z_in = nz;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(CORDIC_STEPS - 1))
               state_in = ST_SCALE;
         end
         ST_SCALE: begin
            for (int l = 0; l < 3; l++) begin
               c_in[l] = to_trig(cc[l]);
               s_in[l] = to_trig(ss[l]);
            end
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            // lane 0 roll (x), 1 pitch (y), 2 yaw (z)
            pr_in[0] = mr(c_ff[2], c_ff[1]);
            pr_in[1] = mr(c_ff[2], s_ff[1]);
            pr_in[2] = mr(s_ff[2], s_ff[1]);
            pr_in[3] = mr(s_ff[2], c_ff[1]);
            pr_in[4] = mr(s_ff[2], c_ff[0]);
            pr_in[5] = mr(c_ff[2], c_ff[0]);
            pr_in[6] = mr(s_ff[2], s_ff[0]);
            pr_in[7] = mr(c_ff[2], s_ff[0]);
            pr_in[8] = mr(c_ff[1], s_ff[0]);
            pr_in[9] = mr(c_ff[1], c_ff[0]);
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            mat_in[0] = sat1((MW + 1)'(pr_ff[0]));
            mat_in[1] = sat1((MW + 1)'(mr(pr_ff[1], s_ff[0])) - (MW + 1)'(pr_ff[4]));
            mat_in[2] = sat1((MW + 1)'(mr(pr_ff[1], c_ff[0])) + (MW + 1)'(pr_ff[6]));
            mat_in[3] = sat1((MW + 1)'(pr_ff[3]));
            mat_in[4] = sat1((MW + 1)'(mr(pr_ff[2], s_ff[0])) + (MW + 1)'(pr_ff[5]));
            mat_in[5] = sat1((MW + 1)'(mr(pr_ff[2], c_ff[0])) - (MW + 1)'(pr_ff[7]));
            mat_in[6] = sat1(-(MW + 1)'(s_ff[1]));
            mat_in[7] = sat1((MW + 1)'(pr_ff[8]));
            mat_in[8] = sat1((MW + 1)'(pr_ff[9]));
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int k = 0; k < 9; k++)
            mat_ff[k] <= (k % 4 == 0) ? MW'(ONE) : '0;
      end else begin
         state_ff <= state_in;
         mat_ff   <= mat_in;
      end
      step_ff <= step_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      q_ff  <= q_in;
      c_ff  <= c_in;
      s_ff  <= s_in;
      pr_ff <= pr_in;
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      for (int k = 0; k < 9; k++)
         mat[k] = mat_ff[k];
   end

endmodule

// ----- hw/rtl/epp_xform.sv -----
`timescale 1ns / 1ps
// Three-stage matrix-vector pipe: products, row sums with rounding,
// scale, offset and saturation. Depends on epp_pkg.
module epp_xform #(
   parameter int CW  = epp_pkg::COORD_WIDTH,
   parameter int TFB = epp_pkg::TRIG_FRACTION_BITS,
   parameter int PW  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  epp_pkg::ctl_type                   in_ctl,
   input  logic [2:0][PW-1:0]                 in_pt,
   input  logic [8:0][TFB+1:0]                mat,
   input  logic [2:0][epp_pkg::CSR_WIDTH-1:0] off,
   output epp_pkg::ctl_type                   out_ctl,
   output logic [2:0][CW-1:0]                 world
);
   import epp_pkg::*;

   localparam int MW = TFB + 2;
   localparam int SW = MW + PW + 1;
   localparam logic signed [SW-1:0] CMAX = (SW'(1) <<< (CW - 1)) - SW'(1);
   localparam logic signed [SW-1:0] CMIN = -CMAX - SW'(1);

   ctl_type                 c1_ff, c2_ff, c3_ff;
   logic signed [MW+PW-1:0] prod_ff [9], prod_in [9];
   logic signed [SW-1:0]    sum_ff [3], sum_in [3];
   logic [CW-1:0]           w_ff [3], w_in [3];
   logic signed [SW-1:0]    shv [3], val [3];
   logic [PW-1:0]           off_raw [3];
   logic signed [CW-1:0]    off_c [3];

   always_comb begin
      for (int k = 0; k < 9; k++)
         prod_in[k] = $signed(mat[k]) * $signed(in_pt[k % 3]);
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = SW'(prod_ff[3 * i]) + SW'(prod_ff[3 * i + 1]) + SW'(prod_ff[3 * i + 2])
                   + (c1_ff.extra ? (SW'(1) <<< TFB) : (SW'(1) <<< (TFB - 1)));
         shv[i] = c2_ff.extra ? (sum_ff[i] >>> (TFB + 1)) : (sum_ff[i] >>> TFB);
         off_raw[i] = PW'(off[i]);
         off_c[i]   = off_raw[i][CW-1:0];
         val[i] = shv[i] + SW'(off_c[i]);
         if (val[i] > CMAX)
            w_in[i] = CMAX[CW-1:0];
         else if (val[i] < CMIN)
            w_in[i] = CMIN[CW-1:0];
         else
            w_in[i] = val[i][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
      end else if (en) begin
         c1_ff <= in_ctl;
         c2_ff <= c1_ff;
         c3_ff <= c2_ff;
      end
      if (en) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
         w_ff    <= w_in;
      end
   end

   assign out_ctl = c3_ff;

   always_comb begin
      for (int i = 0; i < 3; i++)
         world[i] = w_ff[i];
   end

endmodule

// ----- hw/rtl/euler_pose_point_transform_core.sv -----
`timescale 1ns / 1ps
// Euler ZYX pose transform: rotates body points by Rz*Ry*Rx, adds the position.
// Top level; uses epp_pkg, epp_rot and epp_xform.
// A point word is taken every cycle while the input is not stalled, and its result
// is registered through the input, product, row-sum and output stages. A frame
// word issues four corner words, so the input stalls until the last corner word
// has been issued. Writing an angle register rebuilds the matrix in the CORDIC
// unit, one step a cycle; an angle write stalls the input, and writes that land
// during a rebuild queue one more rebuild, so the stall lasts until the rebuild
// after the last angle write has finished.
module euler_pose_point_transform_core #(
   parameter int COORD_WIDTH        = epp_pkg::COORD_WIDTH,
   parameter int TRIG_FRACTION_BITS = epp_pkg::TRIG_FRACTION_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_kind,
   input  logic signed [COORD_WIDTH-1:0]           req_point_x,
   input  logic signed [COORD_WIDTH-1:0]           req_point_y,
   input  logic signed [COORD_WIDTH-1:0]           req_point_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [COORD_WIDTH-1:0]           rsp_world_x,
   output logic signed [COORD_WIDTH-1:0]           rsp_world_y,
   output logic signed [COORD_WIDTH-1:0]           rsp_world_z,
   output logic                                    rsp_last,
   input  logic                                    csr_we,
   input  logic [epp_pkg::CSR_INDEX_WIDTH-1:0]     csr_addr,
   input  logic [epp_pkg::CSR_WIDTH-1:0]           csr_wdata
);
   import epp_pkg::*;

   localparam int PW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
   localparam int MW = TRIG_FRACTION_BITS + 2;

   logic [15:0]               roll_ff, pitch_ff, yaw_ff;
   logic [2:0][CSR_WIDTH-1:0] off_ff;
   logic [30:0]               bwidth_ff, blength_ff;
   logic                      rebuild_ff;
   logic                      frame_ff, frame_in;
   logic [1:0]                corner_ff, corner_in;
   ctl_type                   s0_ctl_ff, s0_ctl_in, out_ctl;
   logic [2:0][PW-1:0]        s0_pt_ff, s0_pt_in, corner_pt;
   logic [8:0][MW-1:0]        mat;
   logic [2:0][COORD_WIDTH-1:0] world;
   logic                      rot_busy, en, take;

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_ff    <= '0;
         pitch_ff   <= '0;
         yaw_ff     <= '0;
         off_ff     <= '0;
         bwidth_ff  <= '0;
         blength_ff <= '0;
         rebuild_ff <= 1'b0;
      end else begin
         // held while a rebuild runs so a later angle write is not lost
         rebuild_ff <= (csr_we && (csr_addr == REG_ROLL || csr_addr == REG_PITCH ||
                                   csr_addr == REG_YAW)) || (rebuild_ff && rot_busy);
         if (csr_we) begin
            case (csr_addr)
               REG_ROLL:     roll_ff    <= csr_wdata[15:0];
               REG_PITCH:    pitch_ff   <= csr_wdata[15:0];
               REG_YAW:      yaw_ff     <= csr_wdata[15:0];
               REG_OFFSET_X: off_ff[0]  <= csr_wdata;
               REG_OFFSET_Y: off_ff[1]  <= csr_wdata;
               REG_OFFSET_Z: off_ff[2]  <= csr_wdata;
               REG_WIDTH:    bwidth_ff  <= csr_wdata[30:0];
               REG_LENGTH:   blength_ff <= csr_wdata[30:0];
               default: ;
            endcase
         end
      end
   end

   epp_rot #(.TFB(TRIG_FRACTION_BITS)) u_rot (
      .clock (clock),
      .reset (reset),
      .start (rebuild_ff),
      .roll  (roll_ff),
      .pitch (pitch_ff),
      .yaw   (yaw_ff),
      .busy  (rot_busy),
      .mat   (mat)
   );

   assign en        = !(out_ctl.valid && rsp_stall);
   assign req_stall = csr_we | rebuild_ff | rot_busy | frame_ff | !en;
   assign take      = req_valid && !req_stall;

   // corners in order dl, dr, ul, ur; doubled so the halving stays exact
   always_comb begin
      corner_pt[0] = corner_ff[0] ? PW'(bwidth_ff) : -PW'(bwidth_ff);
      corner_pt[1] = '0;
      corner_pt[2] = corner_ff[1] ? PW'(blength_ff) : -PW'(blength_ff);
   end

   always_comb begin
      s0_ctl_in = s0_ctl_ff;
      s0_pt_in  = s0_pt_ff;
      frame_in  = frame_ff;
      corner_in = corner_ff;
      if (en) begin
         s0_ctl_in = '0;
         if (frame_ff) begin
            s0_ctl_in = '{valid: 1'b1, last: (corner_ff == 2'd3), extra: 1'b1};
            s0_pt_in  = corner_pt;
            frame_in  = (corner_ff != 2'd3);
            corner_in = corner_ff + 2'd1;
         end else if (take) begin
            if (req_kind) begin
               s0_ctl_in = '{valid: 1'b1, last: 1'b0, extra: 1'b1};
               s0_pt_in  = corner_pt;
               frame_in  = 1'b1;
               corner_in = corner_ff + 2'd1;
            end else begin
               s0_ctl_in   = '{valid: 1'b1, last: 1'b1, extra: 1'b0};
               s0_pt_in[0] = PW'(req_point_x);
               s0_pt_in[1] = PW'(req_point_y);
               s0_pt_in[2] = PW'(req_point_z);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
         frame_ff  <= 1'b0;
         corner_ff <= '0;
      end else begin
         s0_ctl_ff <= s0_ctl_in;
         frame_ff  <= frame_in;
         corner_ff <= corner_in;
      end
      s0_pt_ff <= s0_pt_in;
   end

   epp_xform #(.CW(COORD_WIDTH), .TFB(TRIG_FRACTION_BITS), .PW(PW)) u_xform (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_ctl  (s0_ctl_ff),
      .in_pt   (s0_pt_ff),
      .mat     (mat),
      .off     (off_ff),
      .out_ctl (out_ctl),
      .world   (world)
   );

   assign rsp_valid   = out_ctl.valid;
   assign rsp_last    = out_ctl.last;
   assign rsp_world_x = world[0];
   assign rsp_world_y = world[1];
   assign rsp_world_z = world[2];

   a_frame_blocks: assert property (@(posedge clock) disable iff (reset)
      frame_ff |-> req_stall)
      else $error("word taken while frame corners pending");

   a_rebuild_starts: assert property (@(posedge clock) disable iff (reset)
      (rebuild_ff && !rot_busy) |=> rot_busy)
      else $error("matrix rebuild did not start");

   a_point_single: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !req_kind) |=>
      (s0_ctl_ff.valid && s0_ctl_ff.last && !s0_ctl_ff.extra))
      else $error("point word not issued as single last word");

endmodule
